### rtl/core/trlc_pkg.sv
package trlc_pkg;

    localparam int LETTER_W    = 5;
    localparam int CHAR_W      = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;

    typedef enum logic [1:0] {
        OP_ENCODE = 2'd0,
        OP_DECODE = 2'd1,
        OP_LOAD   = 2'd2,
        OP_OFFSET = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_ENCODE = 2'd0,
        KIND_DECODE = 2'd1,
        KIND_PASS   = 2'd2,
        KIND_LOAD   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [CHAR_W-1:0]     chr;
        logic                  upper;
        logic [LETTER_W-1:0]   addr;
        logic [LETTER_W-1:0]   pos_first;
        logic [LETTER_W-1:0]   pos_second;
        logic                  rotor_sel;
        logic [LETTER_W-1:0]   slot;
        logic [LETTER_W-1:0]   letter;
    } trlc_item_t;

    function automatic logic [LETTER_W-1:0] mod_add(
        input logic [LETTER_W-1:0] a,
        input logic [LETTER_W-1:0] b,
        input logic [LETTER_W:0]   n
    );
        logic [LETTER_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= n)
        begin
            s = s - n;
        end
        return s[LETTER_W-1:0];
    endfunction

    function automatic logic [LETTER_W-1:0] mod_sub(
        input logic [LETTER_W-1:0] a,
        input logic [LETTER_W-1:0] b,
        input logic [LETTER_W:0]   n
    );
        logic [LETTER_W:0] s;
        if (a >= b)
        begin
            s = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            s = {1'b0, a} + n - {1'b0, b};
        end
        return s[LETTER_W-1:0];
    endfunction

endpackage

### rtl/core/two_rotor_letter_cipher_core.sv
// Two-rotor letter substitution cipher, no reflector. Each request on the s_ side carries
// an op in s_tuser: encode or decode a character, load one rotor letter (writes the forward
// entry and its inverse), or set both rotor positions. Encode and decode requests each give
// exactly one character on the m_ side; loads and offset settings give none. Letters a.. and
// A.. within the alphabet keep their case and step the rotors like an odometer (first rotor
// fast); other characters pass through unchanged and do not step. Loads with a slot or letter
// outside the alphabet are dropped; offsets are reduced modulo the alphabet size. Rotor
// tables hold nothing after reset: load every entry before enciphering with it. One request
// is taken per cycle while the queue is not full; a character goes from a queue entry
// through both lookup stage registers to m_tdata. A four-entry queue separates request
// decode from the two lookup stages and takes requests while m_tready is low, until full.
module two_rotor_letter_cipher_core #(
    parameter int ALPHABET_SIZE = 26
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // char_in[7:0], rotor_sel[8], slot[13:9], letter[18:14],
    // offset_first[23:19], offset_second[28:24], zero[31:29]
    input  logic [31:0] s_tdata,
    // op[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // char_out[7:0]
    output logic [7:0]  m_tdata
);
    import trlc_pkg::*;

    logic       push;
    trlc_item_t push_item;
    logic       queue_full;
    logic       pop;
    logic       head_valid;
    trlc_item_t head;

    trlc_front #(
        .ALPHABET_SIZE(ALPHABET_SIZE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    trlc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    trlc_back #(
        .ALPHABET_SIZE(ALPHABET_SIZE)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

### rtl/core/trlc_front.sv
module trlc_front #(
    parameter int ALPHABET_SIZE = 26
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 queue_full,
    output logic                 push,
    output trlc_pkg::trlc_item_t push_item
);
    import trlc_pkg::*;

    localparam logic [LETTER_W:0]   N6   = (LETTER_W+1)'(ALPHABET_SIZE);
    localparam logic [CHAR_W:0]     N9   = (CHAR_W+1)'(ALPHABET_SIZE);
    localparam logic [LETTER_W-1:0] LAST = LETTER_W'(ALPHABET_SIZE - 1);

    function automatic logic [LETTER_W-1:0] reduce(input logic [LETTER_W-1:0] v);
        logic [LETTER_W-1:0] r;
        r = '0;
        for (int i = 0; i < (1 << LETTER_W); i++)
        begin
            if (v == LETTER_W'(i))
            begin
                r = LETTER_W'(i % ALPHABET_SIZE);
            end
        end
        return r;
    endfunction

    logic [LETTER_W-1:0] pos_first_reg, pos_first_next;
    logic [LETTER_W-1:0] pos_second_reg, pos_second_next;

    op_t                 op;
    logic [CHAR_W-1:0]   ch;
    logic [CHAR_W:0]     lower_d;
    logic [CHAR_W:0]     upper_d;
    logic                is_lower;
    logic                is_upper;
    logic [LETTER_W-1:0] idx;
    logic                accept;
    logic                load_ok;

    assign op       = op_t'(s_tuser);
    assign ch       = s_tdata[7:0];
    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    assign lower_d  = {1'b0, ch} - {1'b0, CH_LOWER_A};
    assign upper_d  = {1'b0, ch} - {1'b0, CH_UPPER_A};
    assign is_lower = (ch >= CH_LOWER_A) && (lower_d < N9);
    assign is_upper = !is_lower && (ch >= CH_UPPER_A) && (upper_d < N9);
    assign idx      = is_lower ? lower_d[LETTER_W-1:0] : upper_d[LETTER_W-1:0];
    assign load_ok  = ({1'b0, s_tdata[13:9]} < N6) && ({1'b0, s_tdata[18:14]} < N6);

    always_comb
    begin
        push_item.kind       = KIND_PASS;
        push_item.chr        = ch;
        push_item.upper      = is_upper;
        push_item.addr       = '0;
        push_item.pos_first  = pos_first_reg;
        push_item.pos_second = pos_second_reg;
        push_item.rotor_sel  = s_tdata[8];
        push_item.slot       = s_tdata[13:9];
        push_item.letter     = s_tdata[18:14];
        push                 = 1'b0;
        pos_first_next       = pos_first_reg;
        pos_second_next      = pos_second_reg;

        case (op)
            OP_ENCODE, OP_DECODE:
            begin
                push = accept;
                if (is_lower || is_upper)
                begin
                    if (op == OP_ENCODE)
                    begin
                        push_item.kind = KIND_ENCODE;
                        push_item.addr = mod_add(idx, pos_first_reg, N6);
                    end
                    else
                    begin
                        push_item.kind = KIND_DECODE;
                        push_item.addr = idx;
                    end
                    if (accept)
                    begin
                        // advance like an odometer
                        pos_first_next = (pos_first_reg == LAST) ? '0 : pos_first_reg + 1'b1;
                        if (pos_first_reg == LAST)
                        begin
                            pos_second_next = (pos_second_reg == LAST) ? '0
                                                                       : pos_second_reg + 1'b1;
                        end
                    end
                end
            end
            OP_LOAD:
            begin
                push_item.kind = KIND_LOAD;
                push           = accept && load_ok;
            end
            OP_OFFSET:
            begin
                if (accept)
                begin
                    pos_first_next  = reduce(s_tdata[23:19]);
                    pos_second_next = reduce(s_tdata[28:24]);
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_first_reg  <= '0;
            pos_second_reg <= '0;
        end
        else
        begin
            pos_first_reg  <= pos_first_next;
            pos_second_reg <= pos_second_next;
        end
    end

endmodule

### rtl/core/trlc_queue.sv
module trlc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  trlc_pkg::trlc_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output trlc_pkg::trlc_item_t head
);
    import trlc_pkg::*;

    trlc_item_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [QPTR_W:0]      count_reg, count_next;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/core/trlc_back.sv
module trlc_back #(
    parameter int ALPHABET_SIZE = 26
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  trlc_pkg::trlc_item_t head,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata
);
    import trlc_pkg::*;

    localparam int              IW = $clog2(ALPHABET_SIZE);
    localparam logic [LETTER_W:0] N6 = (LETTER_W+1)'(ALPHABET_SIZE);

    logic [LETTER_W-1:0] fwd0_reg [ALPHABET_SIZE];
    logic [LETTER_W-1:0] fwd1_reg [ALPHABET_SIZE];
    logic [LETTER_W-1:0] inv0_reg [ALPHABET_SIZE];
    logic [LETTER_W-1:0] inv1_reg [ALPHABET_SIZE];

    logic                s2_valid_reg;
    trlc_item_t          s2_reg;
    logic [LETTER_W-1:0] rd1_reg;

    logic                s3_valid_reg;
    kind_t               s3_kind_reg;
    logic                s3_upper_reg;
    logic [CHAR_W-1:0]   s3_chr_reg;
    logic [LETTER_W-1:0] s3_pos_first_reg;
    logic [LETTER_W-1:0] rd2_reg;

    logic                en;
    logic                s2_go;
    logic [LETTER_W-1:0] addr2;
    logic [CHAR_W-1:0]   base;

    assign en       = !s3_valid_reg || m_tready;
    assign pop      = en && head_valid;
    assign s2_go    = en && s2_valid_reg;
    assign m_tvalid = s3_valid_reg;

    assign addr2 = (s2_reg.kind == KIND_DECODE) ? mod_sub(rd1_reg, s2_reg.pos_second, N6)
                                                : mod_add(rd1_reg, s2_reg.pos_second, N6);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= head_valid;
            s3_valid_reg <= s2_valid_reg && (s2_reg.kind != KIND_LOAD);
        end
    end

    // first lookup: forward table of the first rotor, inverse table of the second
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s2_reg  <= head;
            rd1_reg <= (head.kind == KIND_DECODE) ? inv1_reg[head.addr[IW-1:0]]
                                                  : fwd0_reg[head.addr[IW-1:0]];
            if (head.kind == KIND_LOAD)
            begin
                if (!head.rotor_sel)
                begin
                    fwd0_reg[head.slot[IW-1:0]] <= head.letter;
                end
                else
                begin
                    inv1_reg[head.letter[IW-1:0]] <= head.slot;
                end
            end
        end
    end

    // second lookup: forward table of the second rotor, inverse table of the first
    always_ff @(posedge clk)
    begin
        if (s2_go)
        begin
            s3_kind_reg      <= s2_reg.kind;
            s3_upper_reg     <= s2_reg.upper;
            s3_chr_reg       <= s2_reg.chr;
            s3_pos_first_reg <= s2_reg.pos_first;
            rd2_reg          <= (s2_reg.kind == KIND_DECODE) ? inv0_reg[addr2[IW-1:0]]
                                                             : fwd1_reg[addr2[IW-1:0]];
            if (s2_reg.kind == KIND_LOAD)
            begin
                if (s2_reg.rotor_sel)
                begin
                    fwd1_reg[s2_reg.slot[IW-1:0]] <= s2_reg.letter;
                end
                else
                begin
                    inv0_reg[s2_reg.letter[IW-1:0]] <= s2_reg.slot;
                end
            end
        end
    end

    assign base = s3_upper_reg ? CH_UPPER_A : CH_LOWER_A;

    always_comb
    begin
        case (s3_kind_reg)
            KIND_ENCODE:
            begin
                m_tdata = base + {3'b000, rd2_reg};
            end
            KIND_DECODE:
            begin
                m_tdata = base + {3'b000, mod_sub(rd2_reg, s3_pos_first_reg, N6)};
            end
            default:
            begin
                m_tdata = s3_chr_reg;
            end
        endcase
    end

endmodule

### verif/two_rotor_letter_cipher_core_tb.sv
module two_rotor_letter_cipher_core_tb;

    import trlc_pkg::*;

    localparam int ALPHABET_SIZE = 26;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_CYCLES  = 16;

    typedef struct {
        op_t         op;
        logic [7:0]  chr;
        logic        rotor_sel;
        logic [4:0]  slot;
        logic [4:0]  letter;
        logic [4:0]  off_first;
        logic [4:0]  off_second;
    } cipher_request_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = OP_ENCODE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    int rotor_fwd [2][ALPHABET_SIZE];
    int rotor_inv [2][ALPHABET_SIZE];
    int pos_fast;
    int pos_slow;

    logic [7:0] expected_chars [$];

    int tx_idle_pct;
    int rx_idle_pct;
    int error_count;
    int cycle_count;
    int n_encode;
    int n_decode;
    int n_pass;
    int n_load;
    int n_offset;

    two_rotor_letter_cipher_core #(
        .ALPHABET_SIZE(ALPHABET_SIZE)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("two_rotor_letter_cipher_core: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin : check_result
        logic [7:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("char_out unexpected: expected none, got %h", m_tdata);
                error_count++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (m_tdata !== want)
                begin
                    $error("char_out: expected %h, got %h", want, m_tdata);
                    error_count++;
                end
            end
        end
    end

    function automatic cipher_request_t random_request();
        cipher_request_t req;
        req.op         = op_t'($urandom_range(3));
        req.chr        = 8'($urandom_range(255));
        req.rotor_sel  = 1'($urandom_range(1));
        req.slot       = 5'($urandom_range(31));
        req.letter     = 5'($urandom_range(31));
        req.off_first  = 5'($urandom_range(31));
        req.off_second = 5'($urandom_range(31));
        return req;
    endfunction

    function automatic cipher_request_t make_char(op_t op, logic [7:0] chr);
        cipher_request_t req;
        req     = random_request();
        req.op  = op;
        req.chr = chr;
        return req;
    endfunction

    function automatic cipher_request_t make_load(logic sel, logic [4:0] slot,
                                                  logic [4:0] letter);
        cipher_request_t req;
        req           = random_request();
        req.op        = OP_LOAD;
        req.rotor_sel = sel;
        req.slot      = slot;
        req.letter    = letter;
        return req;
    endfunction

    function automatic cipher_request_t make_offset(logic [4:0] first, logic [4:0] second);
        cipher_request_t req;
        req            = random_request();
        req.op         = OP_OFFSET;
        req.off_first  = first;
        req.off_second = second;
        return req;
    endfunction

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 40)
        begin
            return CH_LOWER_A + 8'($urandom_range(ALPHABET_SIZE - 1));
        end
        else if (r < 80)
        begin
            return CH_UPPER_A + 8'($urandom_range(ALPHABET_SIZE - 1));
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic int rotor_letter(op_t op, int idx);
        int mid;
        int t;
        if (op == OP_ENCODE)
        begin
            mid = rotor_fwd[0][(idx + pos_fast) % ALPHABET_SIZE];
            return rotor_fwd[1][(mid % ALPHABET_SIZE + pos_slow) % ALPHABET_SIZE]
                   % ALPHABET_SIZE;
        end
        t   = rotor_inv[1][idx] % ALPHABET_SIZE;
        mid = (t + ALPHABET_SIZE - pos_slow) % ALPHABET_SIZE;
        t   = rotor_inv[0][mid] % ALPHABET_SIZE;
        return (t + ALPHABET_SIZE - pos_fast) % ALPHABET_SIZE;
    endfunction

    function automatic logic [7:0] predict_request(cipher_request_t req);
        int base;
        int res;
        logic [7:0] out;
        out = req.chr;
        case (req.op)
            OP_LOAD:
            begin
                n_load++;
                if (req.slot < ALPHABET_SIZE && req.letter < ALPHABET_SIZE)
                begin
                    rotor_fwd[req.rotor_sel][req.slot]   = int'(req.letter);
                    rotor_inv[req.rotor_sel][req.letter] = int'(req.slot);
                end
            end
            OP_OFFSET:
            begin
                n_offset++;
                pos_fast = req.off_first % ALPHABET_SIZE;
                pos_slow = req.off_second % ALPHABET_SIZE;
            end
            default:
            begin
                if (req.op == OP_ENCODE)
                begin
                    n_encode++;
                end
                else
                begin
                    n_decode++;
                end
                base = -1;
                if (req.chr >= CH_LOWER_A && req.chr - CH_LOWER_A < ALPHABET_SIZE)
                begin
                    base = int'(CH_LOWER_A);
                end
                else if (req.chr >= CH_UPPER_A && req.chr - CH_UPPER_A < ALPHABET_SIZE)
                begin
                    base = int'(CH_UPPER_A);
                end
                if (base < 0)
                begin
                    n_pass++;
                end
                else
                begin
                    res = rotor_letter(req.op, int'(req.chr) - base);
                    pos_fast = (pos_fast + 1) % ALPHABET_SIZE;
                    if (pos_fast == 0)
                    begin
                        pos_slow = (pos_slow + 1) % ALPHABET_SIZE;
                    end
                    out = 8'(base + res);
                end
                expected_chars.push_back(out);
            end
        endcase
        return out;
    endfunction

    task automatic send_request(input cipher_request_t req, output logic [7:0] result);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, req.off_second, req.off_first, req.letter, req.slot,
                     req.rotor_sel, req.chr};
        s_tuser  <= req.op;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        result = predict_request(req);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_random_rotors(inout int sent);
        int perm [ALPHABET_SIZE];
        int j;
        int tmp;
        logic [7:0] junk;
        for (int r = 0; r < 2; r++)
        begin
            for (int i = 0; i < ALPHABET_SIZE; i++)
            begin
                perm[i] = i;
            end
            for (int i = ALPHABET_SIZE - 1; i > 0; i--)
            begin
                j       = $urandom_range(i);
                tmp     = perm[i];
                perm[i] = perm[j];
                perm[j] = tmp;
            end
            for (int i = 0; i < ALPHABET_SIZE; i++)
            begin
                send_request(make_load(r[0], 5'(i), 5'(perm[i])), junk);
                sent++;
            end
        end
    endtask

    task automatic test_passthrough_before_load();
        logic [7:0] junk;
        logic [7:0] odd_chars [8] = '{8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B,
                                      8'h80, 8'hE1};
        foreach (odd_chars[i])
        begin
            send_request(make_char(op_t'(i % 2), odd_chars[i]), junk);
        end
    endtask

    task automatic test_rotor_load();
        int sent;
        sent = 0;
        load_random_rotors(sent);
    endtask

    task automatic test_directed();
        logic [7:0] junk;
        send_request(make_char(OP_ENCODE, "a"), junk);
        send_request(make_char(OP_ENCODE, "z"), junk);
        send_request(make_char(OP_DECODE, "A"), junk);
        send_request(make_char(OP_DECODE, "Z"), junk);
        // both rotors wrap on the next letter
        send_request(make_offset(5'd25, 5'd25), junk);
        send_request(make_char(OP_ENCODE, "m"), junk);
        send_request(make_char(OP_ENCODE, "N"), junk);
        send_request(make_offset(5'd25, 5'd3), junk);
        send_request(make_char(OP_DECODE, "Q"), junk);
        send_request(make_offset(5'd31, 5'd31), junk);
        send_request(make_char(OP_ENCODE, "b"), junk);
        send_request(make_offset(5'd0, 5'd0), junk);
        // loads outside the alphabet must be dropped
        send_request(make_load(1'b0, 5'd31, 5'd3), junk);
        send_request(make_load(1'b1, 5'd4, 5'd26), junk);
        send_request(make_load(1'b1, 5'd26, 5'd31), junk);
        send_request(make_char(OP_ENCODE, "c"), junk);
        send_request(make_char(OP_DECODE, "C"), junk);
        send_request(make_load(1'b0, 5'd0, 5'd0), junk);
        send_request(make_load(1'b1, 5'd25, 5'd25), junk);
        send_request(make_char(OP_ENCODE, "a"), junk);
        send_request(make_char(OP_DECODE, "Z"), junk);
        send_request(make_char(OP_ENCODE, "%"), junk);
    endtask

    task automatic test_random_traffic(input int items);
        int sent;
        int len;
        int r;
        logic [4:0] first;
        logic [4:0] second;
        op_t fwd_op;
        op_t back_op;
        logic [7:0] ciphered [16];
        logic [7:0] junk;
        sent = 0;
        load_random_rotors(sent);
        while (sent < items)
        begin
            r = $urandom_range(99);
            if (r < 65)
            begin
                // message out and back at the same starting positions
                len     = $urandom_range(16, 1);
                first   = 5'($urandom_range(31));
                second  = 5'($urandom_range(31));
                fwd_op  = ($urandom_range(1) == 0) ? OP_ENCODE : OP_DECODE;
                back_op = (fwd_op == OP_ENCODE) ? OP_DECODE : OP_ENCODE;
                send_request(make_offset(first, second), junk);
                for (int i = 0; i < len; i++)
                begin
                    send_request(make_char(fwd_op, pick_char()), ciphered[i]);
                end
                send_request(make_offset(first, second), junk);
                for (int i = 0; i < len; i++)
                begin
                    send_request(make_char(back_op, ciphered[i]), junk);
                end
                sent += 2 + 2 * len;
            end
            else if (r < 85)
            begin
                send_request(random_request(), junk);
                sent++;
            end
            else
            begin
                len = $urandom_range(20, 1);
                for (int i = 0; i < len; i++)
                begin
                    send_request(make_char(op_t'($urandom_range(1)), pick_char()), junk);
                end
                sent += len;
            end
        end
    endtask

    initial
    begin
        tx_idle_pct = 6;
        rx_idle_pct = 83;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_passthrough_before_load();
        test_rotor_load();
        test_directed();
        test_random_traffic(600);
        hold_until_drained();

        tx_idle_pct = 83;
        rx_idle_pct = 6;
        test_random_traffic(600);
        hold_until_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(600);
        hold_until_drained();

        $display("Ran %0d encodes and %0d decodes (%0d non-letters passed through),",
                 n_encode, n_decode, n_pass);
        $display("with %0d rotor loads and %0d position settings under three stall mixes.",
                 n_load, n_offset);
        if (error_count == 0)
        begin
            $display("two_rotor_letter_cipher_core: match");
        end
        else
        begin
            $display("two_rotor_letter_cipher_core: mismatch");
        end
        $finish;
    end

endmodule
